@@ sv/pis_pkg.sv @@
package pis_pkg;

    // Varint length limit before a varint is rejected
    localparam int MAX_VARINT_BYTES = 9;

    // Accumulator keeps the low bits of a varint; anything above is a sticky flag
    localparam int ACC_W    = 21;
    localparam int CNT_W    = 21;
    localparam int SEEN_W   = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LEN    = 3'd2;

    localparam logic [3:0] FIELD_NONE     = 4'd0;
    localparam logic [3:0] FIELD_KEY      = 4'd1;
    localparam logic [3:0] FIELD_LISTEN   = 4'd2;
    localparam logic [3:0] FIELD_PROTOCOL = 4'd3;
    localparam logic [3:0] FIELD_OBSERVED = 4'd4;
    localparam logic [3:0] FIELD_PROTO_VER = 4'd5;
    localparam logic [3:0] FIELD_AGENT_VER = 4'd6;
    localparam logic [3:0] FIELD_UNUSED   = 4'd7;
    localparam logic [3:0] FIELD_RECORD   = 4'd8;

    localparam logic [2:0] ROLE_KEY     = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_KEPT    = 3'd2;
    localparam logic [2:0] ROLE_SKIPPED = 3'd3;
    localparam logic [2:0] ROLE_IGNORED = 3'd4;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_TOO_LONG    = 4'd1;
    localparam logic [3:0] ERR_BAD_VARINT  = 4'd2;
    localparam logic [3:0] ERR_WIRE_TYPE   = 4'd3;
    localparam logic [3:0] ERR_WRONG_TYPE  = 4'd4;
    localparam logic [3:0] ERR_FIELD_SIZE  = 4'd5;
    localparam logic [3:0] ERR_LISTENS     = 4'd6;
    localparam logic [3:0] ERR_PROTOCOLS   = 4'd7;
    localparam logic [3:0] ERR_PROTOCOL_ID = 4'd8;
    localparam logic [3:0] ERR_TRUNCATED   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LISTEN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROTOCOL = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROTO_SZ = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORD   = 4'd7;

    localparam logic [19:0] RST_MAX_TOTAL    = 20'd65536;
    localparam logic [15:0] RST_MAX_KEY      = 16'd4096;
    localparam logic [15:0] RST_MAX_ADDRESS  = 16'd4096;
    localparam logic [7:0]  RST_MAX_LISTEN   = 8'd32;
    localparam logic [7:0]  RST_MAX_PROTOCOL = 8'd64;
    localparam logic [11:0] RST_MAX_PROTO_SZ = 12'd1024;
    localparam logic [11:0] RST_MAX_VERSION  = 12'd1024;
    localparam logic [15:0] RST_MAX_RECORD   = 16'd8192;

    typedef enum logic [1:0] {
        PH_KEY   = 2'd0,
        PH_LEN   = 2'd1,
        PH_PAY   = 2'd2,
        PH_SKIPV = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        VI_MORE = 2'd0,
        VI_DONE = 2'd1,
        VI_BAD  = 2'd2
    } t_varint_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] role;
        logic [3:0] field_tag;
        logic       payload_end;
        logic [3:0] error_code;
        logic       message_end;
        logic       message_ok;
    } t_out_item;

    typedef struct packed {
        logic [19:0] max_total_size;
        logic [15:0] max_key_size;
        logic [15:0] max_address_size;
        logic [7:0]  max_listen_count;
        logic [7:0]  max_protocol_count;
        logic [11:0] max_proto_id_size;
        logic [11:0] max_ver_size;
        logic [15:0] max_record_size;
    } t_limits;

endpackage

@@ sv/pis_parser.sv @@
module pis_parser #(
    parameter int MAX_VARINT_BYTES = pis_pkg::MAX_VARINT_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  pis_pkg::t_in_item   i_item,
    input  pis_pkg::t_limits    i_limits,
    output pis_pkg::t_out_item  o_result
);

    localparam int VB_W = $clog2(MAX_VARINT_BYTES + 1);
    localparam logic [VB_W-1:0] VB_MAX = VB_W'(MAX_VARINT_BYTES);
    localparam int ACC_W = pis_pkg::ACC_W;
    localparam int CNT_W = pis_pkg::CNT_W;
    localparam int SEEN_W = pis_pkg::SEEN_W;

    pis_pkg::t_phase         r_phase, n_phase;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic                    r_acc_hi, n_acc_hi;
    logic [VB_W-1:0]         r_vbytes, n_vbytes;
    logic [3:0]              r_field, n_field;
    logic [ACC_W-1:0]        r_left, n_left;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [SEEN_W-1:0]       r_listen, n_listen;
    logic [SEEN_W-1:0]       r_protos, n_protos;
    logic                    r_first, n_first;
    logic [3:0]              r_error, n_error;

    logic [7:0]              b;
    logic                    fin;
    logic [ACC_W-1:0]        v_acc;
    logic                    v_hi;
    logic [VB_W-1:0]         v_cnt;
    pis_pkg::t_varint_status v_status;
    logic                    v_known;
    logic                    v_zero;
    logic [15:0]             lim;
    logic                    lim_en;
    logic                    too_big;
    logic [CNT_W-1:0]        count_inc;
    logic [ACC_W-1:0]        left_dec;
    logic [3:0]              key_field;
    logic [2:0]              role;
    logic [3:0]              tag;
    logic                    pend;
    logic [3:0]              err;

    assign b   = i_item.data_byte;
    assign fin = i_item.final_byte;

    // Varint byte: merge 7 bits at the current group, flag bits beyond the window
    always_comb begin
        v_acc = r_acc;
        for (int i = 0; i < ACC_W; i++) begin
            if (32'(r_vbytes) == i / 7) begin
                v_acc[i] = r_acc[i] | b[i % 7];
            end
        end
        v_hi = r_acc_hi
            | ((32'(r_vbytes) >= 3) && (32'(r_vbytes) <= 8) && (b[6:0] != 7'd0))
            | ((32'(r_vbytes) == 9) && b[0]);
        v_cnt = r_vbytes + VB_W'(1);
        if (r_vbytes >= VB_MAX) begin
            v_status = pis_pkg::VI_BAD;
        end else if (b[7]) begin
            v_status = (v_cnt >= VB_MAX) ? pis_pkg::VI_BAD : pis_pkg::VI_MORE;
        end else if ((r_vbytes != '0) && (b == 8'd0)) begin
            v_status = pis_pkg::VI_BAD;
        end else begin
            v_status = pis_pkg::VI_DONE;
        end
    end

    assign v_known = !v_hi && (v_acc[ACC_W-1:3] != '0)
                  && (v_acc[ACC_W-1:3] <= (ACC_W-3)'(pis_pkg::FIELD_RECORD))
                  && (v_acc[ACC_W-1:3] != (ACC_W-3)'(pis_pkg::FIELD_UNUSED));
    assign key_field = v_known ? v_acc[6:3] : pis_pkg::FIELD_NONE;
    assign v_zero = !v_hi && (v_acc == '0);

    always_comb begin
        lim_en = 1'b1;
        case (r_field) inside
            pis_pkg::FIELD_KEY:       lim = i_limits.max_key_size;
            pis_pkg::FIELD_LISTEN,
            pis_pkg::FIELD_OBSERVED:  lim = i_limits.max_address_size;
            pis_pkg::FIELD_PROTOCOL:  lim = {4'd0, i_limits.max_proto_id_size};
            pis_pkg::FIELD_PROTO_VER,
            pis_pkg::FIELD_AGENT_VER: lim = {4'd0, i_limits.max_ver_size};
            pis_pkg::FIELD_RECORD:    lim = i_limits.max_record_size;
            default: begin
                lim    = 16'd0;
                lim_en = 1'b0;
            end
        endcase
    end

    assign too_big   = lim_en && (v_hi || (v_acc > ACC_W'(lim)));
    assign count_inc = (r_count != '1) ? r_count + CNT_W'(1) : r_count;
    assign left_dec  = (r_left != '0) ? r_left - ACC_W'(1) : r_left;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_acc_hi = r_acc_hi;
        n_vbytes = r_vbytes;
        n_field  = r_field;
        n_left   = r_left;
        n_count  = r_count;
        n_listen = r_listen;
        n_protos = r_protos;
        n_first  = r_first;
        n_error  = r_error;
        role     = pis_pkg::ROLE_IGNORED;
        tag      = pis_pkg::FIELD_NONE;
        pend     = 1'b0;
        err      = pis_pkg::ERR_NONE;

        if (r_error == pis_pkg::ERR_NONE) begin
            n_count = count_inc;
            if (count_inc > {1'b0, i_limits.max_total_size}) begin
                err = pis_pkg::ERR_TOO_LONG;
            end else if (r_phase == pis_pkg::PH_PAY) begin
                role = (r_field != pis_pkg::FIELD_NONE) ? pis_pkg::ROLE_KEPT
                                                        : pis_pkg::ROLE_SKIPPED;
                tag = r_field;
                if ((r_field == pis_pkg::FIELD_PROTOCOL) && r_first && (b != pis_pkg::SLASH_CHAR)) begin
                    err = pis_pkg::ERR_PROTOCOL_ID;
                end
                n_first = 1'b0;
                n_left  = left_dec;
                if (left_dec == '0) begin
                    pend    = 1'b1;
                    n_phase = pis_pkg::PH_KEY;
                end
            end else begin
                unique case (r_phase)
                    pis_pkg::PH_KEY:   role = pis_pkg::ROLE_KEY;
                    pis_pkg::PH_LEN:   role = pis_pkg::ROLE_LENGTH;
                    default:           role = pis_pkg::ROLE_SKIPPED;
                endcase
                tag = (r_phase == pis_pkg::PH_LEN) ? r_field : pis_pkg::FIELD_NONE;
                unique case (v_status)
                    pis_pkg::VI_BAD: begin
                        err = pis_pkg::ERR_BAD_VARINT;
                    end
                    pis_pkg::VI_MORE: begin
                        n_acc    = v_acc;
                        n_acc_hi = v_hi;
                        n_vbytes = v_cnt;
                    end
                    default: begin
                        n_acc    = '0;
                        n_acc_hi = 1'b0;
                        n_vbytes = '0;
                        if (r_phase == pis_pkg::PH_SKIPV) begin
                            pend    = 1'b1;
                            n_phase = pis_pkg::PH_KEY;
                        end else if (r_phase == pis_pkg::PH_KEY) begin
                            if ((v_acc[2:0] != pis_pkg::WIRE_VARINT)
                                    && (v_acc[2:0] != pis_pkg::WIRE_LEN)) begin
                                err = pis_pkg::ERR_WIRE_TYPE;
                            end else if (v_acc[2:0] == pis_pkg::WIRE_VARINT) begin
                                if (v_known) begin
                                    err = pis_pkg::ERR_WRONG_TYPE;
                                end else begin
                                    n_phase = pis_pkg::PH_SKIPV;
                                end
                            end else begin
                                n_field = key_field;
                                tag     = key_field;
                                if (key_field == pis_pkg::FIELD_LISTEN) begin
                                    if (r_listen >= {1'b0, i_limits.max_listen_count}) begin
                                        err = pis_pkg::ERR_LISTENS;
                                    end
                                    if (r_listen != '1) begin
                                        n_listen = r_listen + SEEN_W'(1);
                                    end
                                end else if (key_field == pis_pkg::FIELD_PROTOCOL) begin
                                    if (r_protos >= {1'b0, i_limits.max_protocol_count}) begin
                                        err = pis_pkg::ERR_PROTOCOLS;
                                    end
                                    if (r_protos != '1) begin
                                        n_protos = r_protos + SEEN_W'(1);
                                    end
                                end
                                n_phase = pis_pkg::PH_LEN;
                            end
                        end else begin
                            if (fin && !v_zero) begin
                                err = pis_pkg::ERR_TRUNCATED;
                            end else if (too_big) begin
                                err = pis_pkg::ERR_FIELD_SIZE;
                            end else if (v_zero) begin
                                pend = 1'b1;
                                if (r_field == pis_pkg::FIELD_PROTOCOL) begin
                                    err = pis_pkg::ERR_PROTOCOL_ID;
                                end
                                n_phase = pis_pkg::PH_KEY;
                            end else begin
                                // saturate: a length past the window never drains
                                n_left  = v_hi ? '1 : v_acc;
                                n_first = 1'b1;
                                n_phase = pis_pkg::PH_PAY;
                            end
                        end
                    end
                endcase
            end
            if ((err == pis_pkg::ERR_NONE) && fin && (n_phase != pis_pkg::PH_KEY)) begin
                err = pis_pkg::ERR_TRUNCATED;
            end
            if (err != pis_pkg::ERR_NONE) begin
                n_error = err;
            end
        end

        o_result.byte_out    = b;
        o_result.role        = role;
        o_result.field_tag   = tag;
        o_result.payload_end = pend;
        o_result.error_code  = n_error;
        o_result.message_end = fin;
        o_result.message_ok  = fin && (n_error == pis_pkg::ERR_NONE);

        if (fin) begin
            n_phase  = pis_pkg::PH_KEY;
            n_acc    = '0;
            n_acc_hi = 1'b0;
            n_vbytes = '0;
            n_field  = pis_pkg::FIELD_NONE;
            n_left   = '0;
            n_count  = '0;
            n_listen = '0;
            n_protos = '0;
            n_first  = 1'b0;
            n_error  = pis_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pis_pkg::PH_KEY;
            r_acc    <= '0;
            r_acc_hi <= 1'b0;
            r_vbytes <= '0;
            r_field  <= pis_pkg::FIELD_NONE;
            r_left   <= '0;
            r_count  <= '0;
            r_listen <= '0;
            r_protos <= '0;
            r_first  <= 1'b0;
            r_error  <= pis_pkg::ERR_NONE;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_acc_hi <= n_acc_hi;
            r_vbytes <= n_vbytes;
            r_field  <= n_field;
            r_left   <= n_left;
            r_count  <= n_count;
            r_listen <= n_listen;
            r_protos <= n_protos;
            r_first  <= n_first;
            r_error  <= n_error;
        end
    end

endmodule

@@ sv/protobuf_identify_stream_checker.sv @@
// Streaming checker for protobuf Identify messages, one byte per item.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): one raw message byte
// and a flag marking the last byte of the message.
// Output channel (o_out_valid / i_out_stall, payload o_out): the same byte
// tagged with its role (key, length, kept payload, skipped, ignored), the
// known field number, payload end, the latched error code and, on the last
// byte, message end and message ok.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): register
// index and data; write only while no item is in flight.
//
// An accepted item lands in the input register, is decoded against the parse
// registers and moves into the output register once that register is free.
// Throughput is one item per cycle while the receiver does not stall: the
// decode is a single pass of short logic per byte, so the parse registers
// never hold an item back.
// When the receiver stalls, the output register holds its item and the input
// register fills; o_in_stall rises only once both are occupied.
// Reset (synchronous, active low) empties both registers, clears the parse
// state and loads the default limits.
module protobuf_identify_stream_checker #(
    parameter int MAX_VARINT_BYTES = pis_pkg::MAX_VARINT_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  pis_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output pis_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pis_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pis_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic               r_in_valid;
    pis_pkg::t_in_item  r_in;
    logic               r_out_valid;
    pis_pkg::t_out_item r_out;
    pis_pkg::t_limits   r_limits;
    pis_pkg::t_out_item result;
    logic               out_free;
    logic               fire;
    logic               in_free;
    logic               in_accept;

    // Handshake: the output register frees when empty or being taken;
    // the input register frees when empty or advancing into the output.
    assign out_free  = !r_out_valid || !i_out_stall;
    assign fire      = r_in_valid && out_free;
    assign in_free   = !r_in_valid || fire;
    assign in_accept = i_in_valid && in_free;

    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_accept || (r_in_valid && !fire);
            r_out_valid <= fire || (r_out_valid && i_out_stall);
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    // Limit registers; truncate the write data to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.max_total_size     <= pis_pkg::RST_MAX_TOTAL;
            r_limits.max_key_size       <= pis_pkg::RST_MAX_KEY;
            r_limits.max_address_size   <= pis_pkg::RST_MAX_ADDRESS;
            r_limits.max_listen_count   <= pis_pkg::RST_MAX_LISTEN;
            r_limits.max_protocol_count <= pis_pkg::RST_MAX_PROTOCOL;
            r_limits.max_proto_id_size  <= pis_pkg::RST_MAX_PROTO_SZ;
            r_limits.max_ver_size       <= pis_pkg::RST_MAX_VERSION;
            r_limits.max_record_size    <= pis_pkg::RST_MAX_RECORD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pis_pkg::CFG_MAX_TOTAL:    r_limits.max_total_size     <= i_cfg_data;
                pis_pkg::CFG_MAX_KEY:      r_limits.max_key_size       <= i_cfg_data[15:0];
                pis_pkg::CFG_MAX_ADDRESS:  r_limits.max_address_size   <= i_cfg_data[15:0];
                pis_pkg::CFG_MAX_LISTEN:   r_limits.max_listen_count   <= i_cfg_data[7:0];
                pis_pkg::CFG_MAX_PROTOCOL: r_limits.max_protocol_count <= i_cfg_data[7:0];
                pis_pkg::CFG_MAX_PROTO_SZ: r_limits.max_proto_id_size  <= i_cfg_data[11:0];
                pis_pkg::CFG_MAX_VERSION:  r_limits.max_ver_size       <= i_cfg_data[11:0];
                pis_pkg::CFG_MAX_RECORD:   r_limits.max_record_size    <= i_cfg_data[15:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // Byte decode: parse state advances only when the item moves on
    pis_parser #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_limits (r_limits),
        .o_result (result)
    );

endmodule

@@ sv/pis_checker.sv @@
module pis_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input pis_pkg::t_out_item o_out
);

    logic [3:0] r_held_err;

    // Track the error carried by the last delivered item of an open message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_err <= pis_pkg::ERR_NONE;
        end else if (o_out_valid && !i_out_stall) begin
            r_held_err <= o_out.message_end ? pis_pkg::ERR_NONE : o_out.error_code;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("output item changed while stalled");

    a_ok_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.message_ok
            == (o_out.message_end && (o_out.error_code == pis_pkg::ERR_NONE))))
        else $error("message_ok disagrees with message_end and error_code");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.role == pis_pkg::ROLE_IGNORED))
            |-> (!o_out.payload_end && (o_out.field_tag == pis_pkg::FIELD_NONE)))
        else $error("ignored item carries a tag or payload end");

    a_error_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_held_err != pis_pkg::ERR_NONE))
            |-> (o_out.error_code == r_held_err))
        else $error("latched error changed before message end");

endmodule

bind protobuf_identify_stream_checker pis_checker u_pis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

@@ tb/protobuf_identify_stream_checker_tb.sv @@
// Tracks the parse of the Identify byte stream and holds the tagged bytes
// that the checker must return, oldest first.
class tag_scoreboard;
    pis_pkg::t_limits     lim;
    pis_pkg::t_phase      phase;
    logic [63:0]          acc;
    int unsigned          vbytes;
    logic [3:0]           field;
    logic [63:0]          left_bytes;
    int unsigned          total;
    int unsigned          listens;
    int unsigned          protocols;
    bit                   at_first;
    logic [3:0]           err_latched;
    pis_pkg::t_out_item   expected_tags[$];
    int                   failures;

    function new();
        lim.max_total_size     = pis_pkg::RST_MAX_TOTAL;
        lim.max_key_size       = pis_pkg::RST_MAX_KEY;
        lim.max_address_size   = pis_pkg::RST_MAX_ADDRESS;
        lim.max_listen_count   = pis_pkg::RST_MAX_LISTEN;
        lim.max_protocol_count = pis_pkg::RST_MAX_PROTOCOL;
        lim.max_proto_id_size  = pis_pkg::RST_MAX_PROTO_SZ;
        lim.max_ver_size       = pis_pkg::RST_MAX_VERSION;
        lim.max_record_size    = pis_pkg::RST_MAX_RECORD;
        failures = 0;
        clear_message();
    endfunction

    function void clear_message();
        phase       = pis_pkg::PH_KEY;
        acc         = '0;
        vbytes      = 0;
        field       = pis_pkg::FIELD_NONE;
        left_bytes  = '0;
        total       = 0;
        listens     = 0;
        protocols   = 0;
        at_first    = 1'b0;
        err_latched = pis_pkg::ERR_NONE;
    endfunction

    function void set_limit(logic [pis_pkg::CFG_IDX_W-1:0] idx,
                            logic [pis_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            pis_pkg::CFG_MAX_TOTAL:    lim.max_total_size     = data;
            pis_pkg::CFG_MAX_KEY:      lim.max_key_size       = data[15:0];
            pis_pkg::CFG_MAX_ADDRESS:  lim.max_address_size   = data[15:0];
            pis_pkg::CFG_MAX_LISTEN:   lim.max_listen_count   = data[7:0];
            pis_pkg::CFG_MAX_PROTOCOL: lim.max_protocol_count = data[7:0];
            pis_pkg::CFG_MAX_PROTO_SZ: lim.max_proto_id_size  = data[11:0];
            pis_pkg::CFG_MAX_VERSION:  lim.max_ver_size       = data[11:0];
            pis_pkg::CFG_MAX_RECORD:   lim.max_record_size    = data[15:0];
            default: ;
        endcase
    endfunction

    function pis_pkg::t_varint_status take_varint(logic [7:0] b);
        if (vbytes >= pis_pkg::MAX_VARINT_BYTES)
            return pis_pkg::VI_BAD;
        acc = acc | (64'(b[6:0]) << (7 * vbytes));
        vbytes++;
        if (b[7]) begin
            if (vbytes >= pis_pkg::MAX_VARINT_BYTES)
                return pis_pkg::VI_BAD;
            return pis_pkg::VI_MORE;
        end
        // a trailing zero byte means the varint was padded
        if (vbytes > 1 && b == 8'h00)
            return pis_pkg::VI_BAD;
        return pis_pkg::VI_DONE;
    endfunction

    function logic [63:0] size_limit(logic [3:0] f);
        case (f)
            pis_pkg::FIELD_KEY:
                return 64'(lim.max_key_size);
            pis_pkg::FIELD_LISTEN, pis_pkg::FIELD_OBSERVED:
                return 64'(lim.max_address_size);
            pis_pkg::FIELD_PROTOCOL:
                return 64'(lim.max_proto_id_size);
            pis_pkg::FIELD_PROTO_VER, pis_pkg::FIELD_AGENT_VER:
                return 64'(lim.max_ver_size);
            pis_pkg::FIELD_RECORD:
                return 64'(lim.max_record_size);
            default:
                return '1;
        endcase
    endfunction

    function bit known_field(logic [63:0] f);
        return f >= 1 && f <= 8 && f != 7;
    endfunction

    function pis_pkg::t_out_item predict_tagged_byte(pis_pkg::t_in_item it);
        pis_pkg::t_out_item      o;
        logic [7:0]              b;
        bit                      fin;
        logic [2:0]              role;
        logic [3:0]              tag;
        logic [3:0]              err;
        bit                      pend;
        pis_pkg::t_phase         ph;
        pis_pkg::t_varint_status st;
        logic [63:0]             v;
        logic [63:0]             fnum;
        logic [2:0]              wt;
        b    = it.data_byte;
        fin  = it.final_byte;
        role = pis_pkg::ROLE_IGNORED;
        tag  = pis_pkg::FIELD_NONE;
        pend = 1'b0;
        err  = pis_pkg::ERR_NONE;
        if (err_latched == pis_pkg::ERR_NONE) begin
            if (total < (1 << pis_pkg::CNT_W) - 1)
                total++;
            if (total > lim.max_total_size) begin
                err = pis_pkg::ERR_TOO_LONG;
            end else if (phase != pis_pkg::PH_PAY) begin
                ph   = phase;
                role = (ph == pis_pkg::PH_KEY) ? pis_pkg::ROLE_KEY
                     : (ph == pis_pkg::PH_LEN) ? pis_pkg::ROLE_LENGTH
                     : pis_pkg::ROLE_SKIPPED;
                tag  = (ph == pis_pkg::PH_LEN) ? field : pis_pkg::FIELD_NONE;
                st   = take_varint(b);
                if (st == pis_pkg::VI_BAD) begin
                    err = pis_pkg::ERR_BAD_VARINT;
                end else if (st == pis_pkg::VI_DONE) begin
                    v      = acc;
                    acc    = '0;
                    vbytes = 0;
                    if (ph == pis_pkg::PH_SKIPV) begin
                        pend  = 1'b1;
                        phase = pis_pkg::PH_KEY;
                    end else if (ph == pis_pkg::PH_KEY) begin
                        wt   = v[2:0];
                        fnum = v >> 3;
                        if (wt != pis_pkg::WIRE_VARINT && wt != pis_pkg::WIRE_LEN) begin
                            err = pis_pkg::ERR_WIRE_TYPE;
                        end else if (wt == pis_pkg::WIRE_VARINT) begin
                            if (known_field(fnum))
                                err = pis_pkg::ERR_WRONG_TYPE;
                            else
                                phase = pis_pkg::PH_SKIPV;
                        end else begin
                            field = known_field(fnum) ? fnum[3:0] : pis_pkg::FIELD_NONE;
                            tag   = field;
                            if (field == pis_pkg::FIELD_LISTEN) begin
                                if (listens >= lim.max_listen_count)
                                    err = pis_pkg::ERR_LISTENS;
                                if (listens < (1 << pis_pkg::SEEN_W) - 1)
                                    listens++;
                            end else if (field == pis_pkg::FIELD_PROTOCOL) begin
                                if (protocols >= lim.max_protocol_count)
                                    err = pis_pkg::ERR_PROTOCOLS;
                                if (protocols < (1 << pis_pkg::SEEN_W) - 1)
                                    protocols++;
                            end
                            phase = pis_pkg::PH_LEN;
                        end
                    end else begin
                        if (fin && v != 0) begin
                            err = pis_pkg::ERR_TRUNCATED;
                        end else if (v > size_limit(field)) begin
                            err = pis_pkg::ERR_FIELD_SIZE;
                        end else if (v == 0) begin
                            pend = 1'b1;
                            if (field == pis_pkg::FIELD_PROTOCOL)
                                err = pis_pkg::ERR_PROTOCOL_ID;
                            phase = pis_pkg::PH_KEY;
                        end else begin
                            left_bytes = v;
                            at_first   = 1'b1;
                            phase      = pis_pkg::PH_PAY;
                        end
                    end
                end
            end else begin
                role = (field != pis_pkg::FIELD_NONE) ? pis_pkg::ROLE_KEPT
                                                      : pis_pkg::ROLE_SKIPPED;
                tag  = field;
                if (field == pis_pkg::FIELD_PROTOCOL && at_first && b != pis_pkg::SLASH_CHAR)
                    err = pis_pkg::ERR_PROTOCOL_ID;
                at_first = 1'b0;
                if (left_bytes > 0)
                    left_bytes--;
                if (left_bytes == 0) begin
                    pend  = 1'b1;
                    phase = pis_pkg::PH_KEY;
                end
            end
            if (err == pis_pkg::ERR_NONE && fin && phase != pis_pkg::PH_KEY)
                err = pis_pkg::ERR_TRUNCATED;
            if (err != pis_pkg::ERR_NONE)
                err_latched = err;
        end
        o.byte_out    = b;
        o.role        = role;
        o.field_tag   = tag;
        o.payload_end = pend;
        o.error_code  = err_latched;
        o.message_end = fin;
        o.message_ok  = fin && err_latched == pis_pkg::ERR_NONE;
        if (fin)
            clear_message();
        return o;
    endfunction

    function void note_byte(pis_pkg::t_in_item it);
        expected_tags.insert(expected_tags.size(), predict_tagged_byte(it));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        // keep the log readable when the block is badly off
        if (failures < 100)
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        failures++;
    endtask

    task check_tagged(pis_pkg::t_out_item got);
        pis_pkg::t_out_item want;
        if (expected_tags.size() == 0) begin
            report("result with nothing pending, byte_out", got.byte_out, 0);
            return;
        end
        want = expected_tags.pop_front();
        if (got.byte_out !== want.byte_out)
            report("byte_out", got.byte_out, want.byte_out);
        if (got.role !== want.role)
            report("role", got.role, want.role);
        if (got.field_tag !== want.field_tag)
            report("field_tag", got.field_tag, want.field_tag);
        if (got.payload_end !== want.payload_end)
            report("payload_end", got.payload_end, want.payload_end);
        if (got.error_code !== want.error_code)
            report("error_code", got.error_code, want.error_code);
        if (got.message_end !== want.message_end)
            report("message_end", got.message_end, want.message_end);
        if (got.message_ok !== want.message_ok)
            report("message_ok", got.message_ok, want.message_ok);
    endtask
endclass

module protobuf_identify_stream_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    pis_pkg::t_in_item              in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    pis_pkg::t_out_item             out_item;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [pis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pis_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    tag_scoreboard sb = new();

    // Traffic shaping, set per phase by the main sequence
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;

    // Bytes of the message being built
    logic [7:0] msg_bytes[$];

    protobuf_identify_stream_checker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: a long hold-off when one is requested, random stalls otherwise
    initial begin
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Check every item that leaves the block; values read here are the
    // ones from before the edge, since all stimulus moves by nonblocking writes
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_tagged(out_item);
    end

    // Offer one byte, idling first at random; hold it until taken
    task automatic send_byte(logic [7:0] b, bit fin);
        pis_pkg::t_in_item it;
        it = '{data_byte: b, final_byte: fin};
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(it);
        items_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Drop valid, then wait until every tagged byte has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_tags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [pis_pkg::CFG_IDX_W-1:0] idx,
                             logic [pis_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_limit(idx, data);
    endtask

    // Load a full set of limits; the block must be idle here
    task automatic apply_limits(pis_pkg::t_limits l);
        write_reg(pis_pkg::CFG_MAX_TOTAL, l.max_total_size);
        write_reg(pis_pkg::CFG_MAX_KEY, 20'(l.max_key_size));
        write_reg(pis_pkg::CFG_MAX_ADDRESS, 20'(l.max_address_size));
        write_reg(pis_pkg::CFG_MAX_LISTEN, 20'(l.max_listen_count));
        write_reg(pis_pkg::CFG_MAX_PROTOCOL, 20'(l.max_protocol_count));
        write_reg(pis_pkg::CFG_MAX_PROTO_SZ, 20'(l.max_proto_id_size));
        write_reg(pis_pkg::CFG_MAX_VERSION, 20'(l.max_ver_size));
        write_reg(pis_pkg::CFG_MAX_RECORD, 20'(l.max_record_size));
        cfg_valid <= 1'b0;
    endtask

    // Limits small enough that size, count and total errors show up often
    function automatic pis_pkg::t_limits tight_limits();
        pis_pkg::t_limits l;
        l.max_total_size     = 20'($urandom_range(6, 90));
        l.max_key_size       = 16'($urandom_range(0, 12));
        l.max_address_size   = 16'($urandom_range(0, 12));
        l.max_listen_count   = 8'($urandom_range(0, 3));
        l.max_protocol_count = 8'($urandom_range(0, 3));
        l.max_proto_id_size  = 12'($urandom_range(0, 12));
        l.max_ver_size       = 12'($urandom_range(0, 12));
        l.max_record_size    = 16'($urandom_range(0, 12));
        return l;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Append one byte to the message being built
    function automatic void add_byte(logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void push_varint(logic [63:0] v);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0)
                b[7] = 1'b1;
            add_byte(b);
        end while (v != 0);
    endfunction

    function automatic logic [63:0] known_pick();
        int unsigned r;
        r = $urandom_range(0, 6);
        return (r == 6) ? 64'(pis_pkg::FIELD_RECORD) : 64'(r + 1);
    endfunction

    function automatic logic [63:0] unknown_pick();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 64'(pis_pkg::FIELD_UNUSED);
        if (r <= 4)
            return 64'($urandom_range(9, 31));
        if (r <= 7)
            return 64'($urandom_range(32, 1 << 20));
        // a known number with a high bit on top must not pass as known
        if (r == 8)
            return known_pick() + (64'd1 << $urandom_range(4, 59));
        return rand64() >> 4;
    endfunction

    // Append one field; return 1 when the length is too big to send whole
    function automatic bit add_field(logic [3:0] forced);
        int unsigned sel;
        int unsigned r;
        int unsigned k;
        logic [63:0] fnum;
        logic [63:0] len;
        logic [63:0] v;
        logic [2:0]  wt;
        logic [7:0]  b;
        sel = (forced != pis_pkg::FIELD_NONE) ? 0 : $urandom_range(0, 99);
        wt  = pis_pkg::WIRE_LEN;
        if (sel < 72) begin
            fnum = (forced != pis_pkg::FIELD_NONE) ? 64'(forced) : known_pick();
        end else if (sel < 84) begin
            fnum = unknown_pick();
        end else if (sel < 94) begin
            fnum = unknown_pick();
            wt   = pis_pkg::WIRE_VARINT;
        end else begin
            // any wire type on a small field number, then junk
            fnum = 64'($urandom_range(0, 40));
            wt   = 3'($urandom_range(0, 7));
        end
        push_varint((fnum << 3) | 64'(wt));
        if (sel >= 94) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            return 1'b0;
        end
        if (wt == pis_pkg::WIRE_VARINT) begin
            // skipped varint of 1 to 9 bytes, minimally encoded
            k = $urandom_range(1, pis_pkg::MAX_VARINT_BYTES);
            v = rand64() >> (64 - 7 * k);
            if (k > 1)
                v[7 * (k - 1)] = 1'b1;
            push_varint(v);
            return 1'b0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 64'($urandom_range(0, 6));
        else if (r < 90)
            len = 64'($urandom_range(7, 20));
        else if (r < 97)
            len = 64'($urandom_range(21, 70));
        else
            len = rand64() >> $urandom_range(0, 63);
        push_varint(len);
        if (len > 100) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
            return 1'b1;
        end
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 0 && fnum == pis_pkg::FIELD_PROTOCOL && $urandom_range(0, 9) != 0)
                b = pis_pkg::SLASH_CHAR;
            add_byte(b);
        end
        return 1'b0;
    endfunction

    // Mostly well-formed messages with random content; some cut short or
    // with a byte overwritten, a few pure noise
    function automatic void build_message();
        int unsigned kind;
        int unsigned nf;
        int unsigned k;
        logic [3:0]  same;
        msg_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
            return;
        end
        same = pis_pkg::FIELD_NONE;
        nf   = $urandom_range(1, 5);
        if (kind < 15) begin
            // repeated listen addresses or protocols to reach the count limits
            same = $urandom_range(0, 1) ? pis_pkg::FIELD_LISTEN : pis_pkg::FIELD_PROTOCOL;
            nf   = $urandom_range(2, 6);
        end
        for (int i = 0; i < nf; i++) begin
            if (add_field(same))
                break;
        end
        if (kind >= 85) begin
            k = $urandom_range(0, msg_bytes.size() - 1);
            if ($urandom_range(0, 1)) begin
                while (msg_bytes.size() > k + 1)
                    void'(msg_bytes.pop_back());
            end else begin
                msg_bytes[k] = 8'($urandom);
            end
        end
    endfunction

    task automatic run_random(int upto);
        while (items_sent < upto) begin
            build_message();
            send_message();
        end
    endtask

    initial begin
        pis_pkg::t_limits l;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages under the reset limits, no idling
        // protocol id with its leading slash
        msg_bytes = '{8'h1A, 8'h01, pis_pkg::SLASH_CHAR};
        send_message();
        // protocol id without the slash
        msg_bytes = '{8'h1A, 8'h01, 8'h78};
        send_message();
        // empty protocol id, flagged on its length byte
        msg_bytes = '{8'h1A, 8'h00};
        send_message();
        // empty public key is fine
        msg_bytes = '{8'h0A, 8'h00};
        send_message();
        // wire type 1
        msg_bytes = '{8'h09};
        send_message();
        // varint wire type on a known field
        msg_bytes = '{8'h08};
        send_message();
        // varint on an unknown field is skipped
        msg_bytes = '{8'h38, 8'hFF, 8'h01};
        send_message();
        // padded key varint
        msg_bytes = '{8'h80, 8'h00};
        send_message();
        // payload cut short by the final byte
        msg_bytes = '{8'h12, 8'h05, 8'h01};
        send_message();
        // final byte on a nonzero length
        msg_bytes = '{8'h12, 8'h05};
        send_message();
        run_random(300);

        // Tight limits, sender idling
        drain();
        apply_limits(tight_limits());
        idle_pct = 53;
        run_random(650);

        // Every limit at its top, receiver stalling
        drain();
        l = '1;
        apply_limits(l);
        idle_pct  = 0;
        stall_pct = 53;
        run_random(950);

        // Zero field and count limits, both sides idling
        drain();
        l = '0;
        l.max_total_size = '1;
        apply_limits(l);
        idle_pct  = 10;
        stall_pct = 10;
        run_random(1050);

        // Zero total size: every message fails on its first byte
        drain();
        l = tight_limits();
        l.max_total_size = '0;
        apply_limits(l);
        run_random(1090);

        // Hold the receiver off so the block fills and stalls its input
        drain();
        apply_limits(tight_limits());
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 300;
        run_random(1350);

        // Mixed limits, both sides idling
        drain();
        l = tight_limits();
        l.max_total_size   = 20'($urandom_range(100, 1048575));
        l.max_address_size = 16'($urandom_range(0, 65535));
        l.max_record_size  = 16'($urandom_range(0, 65535));
        apply_limits(l);
        idle_pct  = 10;
        stall_pct = 10;
        run_random(1750);

        drain();
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
